// File: rtl/wfrm_pkg.sv
// Shared types and constants for the windowed frame rate monitor.
// No dependencies; used by the top level and its checker.
package wfrm_pkg;

  localparam int TIME_BITS_DEF  = 48;
  localparam int COUNT_BITS_DEF = 24;

  localparam int TS_W    = 48;
  localparam int WLEN_W  = 26;
  localparam int RATE_W  = 32;
  localparam int MEAN_W  = 56;
  localparam int FRAC_W  = 8;
  localparam int SCALE_W = 28;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 26'd1000000;
  // 1e6 us per second, times 2^8 for the Q24.8 rate
  localparam logic [SCALE_W-1:0] RATE_SCALE = 28'd256000000;
  localparam logic [MEAN_W-1:0]  MEAN_MAX   = {MEAN_W{1'b1}};
  localparam logic [TS_W-1:0]    TS_MAX     = {TS_W{1'b1}};

  typedef struct packed {
    logic [TS_W-1:0] frame_start_time;
    logic [TS_W-1:0] frame_end_time;
  } frame_t;

  typedef struct packed {
    logic              accepted;
    logic              window_cleared;
    logic              report_valid;
    logic [RATE_W-1:0] frame_rate_q8;
    logic [MEAN_W-1:0] mean_frame_time_q8;
    logic [TS_W-1:0]   longest_frame_time;
  } result_t;

endpackage

// File: rtl/wfrm_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Standalone; shared by the rate and mean computations of the top level.
module wfrm_div #(
  parameter int DIVIDEND_W = 56,
  parameter int DIVISOR_W  = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] qd;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W:0]    partial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // qd shifts dividend bits out at the top and quotient bits in at the bottom
  always_comb begin
    partial = {rem, qd[DIVIDEND_W-1]};
    fits    = partial >= {1'b0, dvs};
    diff    = partial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        qd  <= dividend;
        rem <= '0;
        dvs <= divisor;
        cnt <= CNT_W'(DIVIDEND_W);
      end else if (cnt != '0) begin
        qd  <= {qd[DIVIDEND_W-2:0], fits};
        rem <= fits ? diff[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = qd;

endmodule

// File: rtl/windowed_frame_rate_monitor.sv
// Windowed frame rate monitor, top level.
// Depends on wfrm_pkg and wfrm_div.
//
// Usage:
//   frame channel (frame_valid / frame_stall / frame) carries one frame's start
//   and end timestamps in us. A transfer happens when frame_valid is high and
//   frame_stall is low. The block takes one frame at a time and raises
//   frame_stall until that frame's result has been placed in the output register.
//   result channel (result_valid / result_stall / result) gives exactly one
//   result per frame, in order. The output register holds a result while
//   result_stall is high; the next frame is still taken meanwhile and waits in
//   the block only once its own result is ready.
//   wr_en / wr_data write the window length (us); the user writes only while idle, not enforced.
// States per frame:
//   A counted frame that closes no window passes the check, update and output
//   states; an ignored frame skips the update. A frame that closes a window
//   adds a multiply state and two passes of the shared one-bit-per-cycle divider
//   (rate, then mean), whose width is DIV_W = max(COUNT_BITS+28, TIME_BITS+8).
// Reset (rst, synchronous): window and held statistics clear, the window
//   length returns to 1000000 us, result_valid drops and frames are taken.
module windowed_frame_rate_monitor #(
  parameter int TIME_BITS  = wfrm_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = wfrm_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [wfrm_pkg::WLEN_W-1:0]     wr_data,
  input  logic                            frame_valid,
  output logic                            frame_stall,
  input  wfrm_pkg::frame_t                frame,
  output logic                            result_valid,
  input  logic                            result_stall,
  output wfrm_pkg::result_t               result
);

  localparam int NUM_W      = COUNT_BITS + wfrm_pkg::SCALE_W;
  localparam int MNUM_W     = TIME_BITS + wfrm_pkg::FRAC_W;
  localparam int DIV_W      = (NUM_W > MNUM_W) ? NUM_W : MNUM_W;
  localparam int MEAN_EXT_W = (DIV_W > wfrm_pkg::MEAN_W) ? DIV_W : wfrm_pkg::MEAN_W;
  localparam int LONG_EXT_W = (TIME_BITS > wfrm_pkg::TS_W) ? TIME_BITS : wfrm_pkg::TS_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CHK  = 7'b0000010,
    S_UPD  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_RATE = 7'b0010000,
    S_MEAN = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [wfrm_pkg::WLEN_W-1:0] wlen;
  logic [TIME_BITS-1:0]        start_r;
  logic [TIME_BITS-1:0]        end_r;
  logic [TIME_BITS-1:0]        frame_r;
  logic [TIME_BITS-1:0]        interval_r;
  logic [TIME_BITS-1:0]        window_start;
  logic [TIME_BITS-1:0]        time_sum;
  logic [TIME_BITS-1:0]        longest;
  logic [COUNT_BITS-1:0]       count;
  logic                        acc_r;
  logic                        clr_r;
  logic                        rep_r;
  logic [wfrm_pkg::RATE_W-1:0] rate_held;
  logic [wfrm_pkg::MEAN_W-1:0] mean_held;
  logic [wfrm_pkg::TS_W-1:0]   longest_held;

  // frame check
  logic                 ok;
  logic                 backstep;
  logic [TIME_BITS-1:0] ws_eff;
  // window update
  logic [TIME_BITS-1:0]        sum_base;
  logic [TIME_BITS-1:0]        long_base;
  logic [COUNT_BITS-1:0]       count_base;
  logic [TIME_BITS:0]          sum_add;
  logic [TIME_BITS-1:0]        sum_new;
  logic [TIME_BITS-1:0]        long_new;
  logic [COUNT_BITS-1:0]       count_new;
  logic [wfrm_pkg::WLEN_W-1:0] len;
  logic                        win_done;
  // report
  logic [NUM_W-1:0]            product;
  logic                        div_start;
  logic [DIV_W-1:0]            div_dividend;
  logic [TIME_BITS-1:0]        div_divisor;
  logic                        div_done;
  logic [DIV_W-1:0]            quo;
  logic [wfrm_pkg::RATE_W-1:0] rate_sat;
  logic [MEAN_EXT_W-1:0]       mean_ext;
  logic [wfrm_pkg::MEAN_W-1:0] mean_sat;
  logic [LONG_EXT_W-1:0]       long_ext;
  logic [wfrm_pkg::TS_W-1:0]   long_sat;
  logic                        out_load;

  assign frame_stall = (state != S_IDLE);
  assign out_load    = (state == S_OUT) && (!result_valid || !result_stall);

  always_comb begin
    ok       = (start_r != '0) && (end_r >= start_r);
    backstep = (window_start != '0) && (start_r < window_start);
    ws_eff   = ((window_start == '0) || backstep) ? start_r : window_start;
  end

  // a discarded window restarts from zero
  always_comb begin
    sum_base   = clr_r ? '0 : time_sum;
    long_base  = clr_r ? '0 : longest;
    count_base = clr_r ? '0 : count;
    sum_add    = {1'b0, sum_base} + {1'b0, frame_r};
    sum_new    = sum_add[TIME_BITS] ? '1 : sum_add[TIME_BITS-1:0];
    long_new   = (frame_r > long_base) ? frame_r : long_base;
    count_new  = (&count_base) ? count_base : count_base + COUNT_BITS'(1);
    len        = (wlen == '0) ? wfrm_pkg::WLEN_W'(1) : wlen;
    win_done   = interval_r >= TIME_BITS'(len);
  end

  // shared divider: rate first (count*256e6 / interval), then mean (sum*256 / count)
  always_comb begin
    product      = NUM_W'(count) * NUM_W'(wfrm_pkg::RATE_SCALE);
    div_start    = (state == S_MUL) || ((state == S_RATE) && div_done);
    div_dividend = (state == S_MUL) ? DIV_W'(product)
                                    : DIV_W'({time_sum, {wfrm_pkg::FRAC_W{1'b0}}});
    div_divisor  = (state == S_MUL) ? interval_r : TIME_BITS'(count);
  end

  wfrm_div #(
    .DIVIDEND_W(DIV_W),
    .DIVISOR_W (TIME_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(quo)
  );

  always_comb begin
    rate_sat = (quo[DIV_W-1:wfrm_pkg::RATE_W] != '0) ? '1 : quo[wfrm_pkg::RATE_W-1:0];
    mean_ext = MEAN_EXT_W'(quo);
    mean_sat = (mean_ext > MEAN_EXT_W'(wfrm_pkg::MEAN_MAX)) ? wfrm_pkg::MEAN_MAX
                                                             : mean_ext[wfrm_pkg::MEAN_W-1:0];
    long_ext = LONG_EXT_W'(longest);
    long_sat = (long_ext > LONG_EXT_W'(wfrm_pkg::TS_MAX)) ? wfrm_pkg::TS_MAX
                                                           : long_ext[wfrm_pkg::TS_W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (frame_valid) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        state_next = ok ? S_UPD : S_OUT;
      end
      S_UPD: begin
        state_next = win_done ? S_MUL : S_OUT;
      end
      S_MUL: begin
        state_next = S_RATE;
      end
      S_RATE: begin
        if (div_done) begin
          state_next = S_MEAN;
        end
      end
      S_MEAN: begin
        if (div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      wlen         <= wfrm_pkg::WLEN_RESET;
      window_start <= '0;
      time_sum     <= '0;
      longest      <= '0;
      count        <= '0;
      rate_held    <= '0;
      mean_held    <= '0;
      longest_held <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        wlen <= wr_data;
      end
      if ((state == S_IDLE) && frame_valid) begin
        start_r <= TIME_BITS'(frame.frame_start_time);
        end_r   <= TIME_BITS'(frame.frame_end_time);
      end
      if (state == S_CHK) begin
        acc_r      <= ok;
        clr_r      <= ok && backstep;
        rep_r      <= 1'b0;
        frame_r    <= end_r - start_r;
        interval_r <= end_r - ws_eff;
        if (ok) begin
          window_start <= ws_eff;
        end
      end
      if (state == S_UPD) begin
        time_sum <= sum_new;
        longest  <= long_new;
        count    <= count_new;
        rep_r    <= win_done;
      end
      if ((state == S_RATE) && div_done) begin
        rate_held <= rate_sat;
      end
      if ((state == S_MEAN) && div_done) begin
        mean_held    <= mean_sat;
        longest_held <= long_sat;
        time_sum     <= '0;
        longest      <= '0;
        count        <= '0;
        window_start <= end_r;
      end
      if (out_load) begin
        result_valid               <= 1'b1;
        result.accepted            <= acc_r;
        result.window_cleared      <= clr_r;
        result.report_valid        <= rep_r;
        result.frame_rate_q8       <= rate_held;
        result.mean_frame_time_q8  <= mean_held;
        result.longest_frame_time  <= longest_held;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/wfrm_chk.sv
// Port-level checker for the windowed frame rate monitor, bound to the top level.
// Depends on wfrm_pkg.
module wfrm_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        frame_valid,
  input logic                        frame_stall,
  input logic                        result_valid,
  input logic                        result_stall,
  input wfrm_pkg::result_t           result
);

  // reset leaves the block empty and ready for a frame
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!result_valid && !frame_stall))
    else $error("block not empty and ready after reset");

  // one frame at a time: a transfer makes the block busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && !frame_stall) |=> frame_stall)
    else $error("frame taken while previous one still in work");

  // a cleared window or a report only comes with a counted frame
  a_flags_consistent: assert property (@(posedge clk)
    result_valid |-> (result.accepted ||
                      (!result.window_cleared && !result.report_valid)))
    else $error("report or clear flagged on an ignored frame");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("result changed while stalled");

endmodule

bind windowed_frame_rate_monitor wfrm_chk u_wfrm_chk (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the windowed frame rate monitor.
// Depends on wfrm_pkg and windowed_frame_rate_monitor; keeps its own model of the window.
module tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 150;
  localparam logic [23:0] COUNT_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [wfrm_pkg::WLEN_W-1:0] wr_data = '0;
  logic frame_valid = 1'b0;
  logic frame_stall;
  wfrm_pkg::frame_t frame_in = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  wfrm_pkg::result_t result_out;

  windowed_frame_rate_monitor dut (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_data(wr_data),
    .frame_valid(frame_valid),
    .frame_stall(frame_stall),
    .frame(frame_in),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result_out)
  );

  wfrm_pkg::frame_t pending_frames[$];
  wfrm_pkg::result_t expected_results[$];

  // model of the window and the held statistics
  logic [wfrm_pkg::WLEN_W-1:0] window_len_us = wfrm_pkg::WLEN_RESET;
  logic [wfrm_pkg::TS_W-1:0] win_start = '0;
  logic [wfrm_pkg::TS_W-1:0] sum_us = '0;
  logic [wfrm_pkg::TS_W-1:0] longest_us = '0;
  logic [23:0] frames_in_window = '0;
  logic [wfrm_pkg::RATE_W-1:0] rate_q8_held = '0;
  logic [wfrm_pkg::MEAN_W-1:0] mean_q8_held = '0;
  logic [wfrm_pkg::TS_W-1:0] longest_held_us = '0;

  int gap_max = 3;
  int stall_max = 3;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit frame_taken = 1'b0;
  bit result_taken = 1'b0;
  int idle_cycles = 0;
  int mismatch_count = 0;
  int error_count = 0;
  int result_index = 0;

  // stimulus shaping
  longint unsigned cur_time = 64'd1000;
  int frame_len_max = 20000;
  int frame_gap_max = 2000;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic wfrm_pkg::result_t predict_frame(wfrm_pkg::frame_t f);
    wfrm_pkg::result_t r;
    logic [wfrm_pkg::TS_W-1:0] s, e, dur, span, wl;
    longint unsigned rate, q, rem, cnt;
    r = '0;
    s = f.frame_start_time;
    e = f.frame_end_time;
    if (s != 0 && e >= s) begin
      r.accepted = 1'b1;
      // frame starts before the open window: time went backwards
      if (win_start != 0 && s < win_start) begin
        win_start = '0;
        sum_us = '0;
        longest_us = '0;
        frames_in_window = '0;
        r.window_cleared = 1'b1;
      end
      dur = e - s;
      if (win_start == 0) win_start = s;
      sum_us = (dur > wfrm_pkg::TS_MAX - sum_us) ? wfrm_pkg::TS_MAX : sum_us + dur;
      if (dur > longest_us) longest_us = dur;
      if (frames_in_window != COUNT_MAX) frames_in_window++;
      span = e - win_start;
      wl = (window_len_us == 0) ? 48'd1 : 48'(window_len_us);
      if (span >= wl) begin
        r.report_valid = 1'b1;
        cnt = 64'(frames_in_window);
        rate = (cnt * 64'(wfrm_pkg::RATE_SCALE)) / 64'(span);
        rate_q8_held = (rate > 64'hFFFF_FFFF) ? '1 : rate[wfrm_pkg::RATE_W-1:0];
        q = 64'(sum_us) / cnt;
        rem = 64'(sum_us) % cnt;
        mean_q8_held = wfrm_pkg::MEAN_W'((q << 8) + ((rem << 8) / cnt));
        longest_held_us = longest_us;
        sum_us = '0;
        longest_us = '0;
        frames_in_window = '0;
        win_start = e;
      end
    end
    r.frame_rate_q8 = rate_q8_held;
    r.mean_frame_time_q8 = mean_q8_held;
    r.longest_frame_time = longest_held_us;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result %0d: %s expected %0h, got %0h", result_index, name, want, got);
    end
  endtask

  // transfers on both channels, prediction, checking and the watchdog
  always @(posedge clk) begin
    wfrm_pkg::result_t want;
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (frame_valid && !frame_stall) begin
        expected_results.push_back(predict_frame(frame_in));
        frame_taken = 1'b1;
        moved = 1'b1;
      end
      if (result_valid && !result_stall) begin
        result_taken = 1'b1;
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("result %0d arrived with nothing expected", result_index);
        end else begin
          want = expected_results.pop_front();
          check_field("accepted", 64'(result_out.accepted), 64'(want.accepted));
          check_field("window_cleared", 64'(result_out.window_cleared), 64'(want.window_cleared));
          check_field("report_valid", 64'(result_out.report_valid), 64'(want.report_valid));
          check_field("frame_rate_q8", 64'(result_out.frame_rate_q8), 64'(want.frame_rate_q8));
          check_field("mean_frame_time_q8", 64'(result_out.mean_frame_time_q8),
                      64'(want.mean_frame_time_q8));
          check_field("longest_frame_time", 64'(result_out.longest_frame_time),
                      64'(want.longest_frame_time));
        end
        result_index++;
      end
      if (moved || (pending_frames.size() == 0 && !frame_valid && expected_results.size() == 0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // frame driver: holds a frame until it is taken, then waits its drawn gap
  always @(negedge clk) begin
    if (!rst && !(frame_valid && !frame_taken)) begin
      frame_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        frame_valid <= 1'b0;
      end else if (pending_frames.size() != 0) begin
        frame_in <= pending_frames.pop_front();
        frame_valid <= 1'b1;
        gap_left = $urandom_range(0, gap_max);
      end else begin
        frame_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stall per result, plus a single long hold
  always @(negedge clk) begin
    if (result_taken) begin
      result_taken = 1'b0;
      stall_left = $urandom_range(0, stall_max);
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  function automatic logic [wfrm_pkg::TS_W-1:0] rand_ts();
    return wfrm_pkg::TS_W'({$urandom(), $urandom()});
  endfunction

  task automatic push_frame(logic [wfrm_pkg::TS_W-1:0] s, logic [wfrm_pkg::TS_W-1:0] e);
    wfrm_pkg::frame_t f;
    f.frame_start_time = s;
    f.frame_end_time = e;
    pending_frames.push_back(f);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_frames.size() != 0 || frame_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic start_phase(logic [wfrm_pkg::WLEN_W-1:0] wlen, int gmax, int smax);
    wait_idle();
    @(negedge clk);
    wr_en <= 1'b1;
    wr_data <= wlen;
    @(negedge clk);
    wr_en <= 1'b0;
    window_len_us = wlen;
    gap_max = gmax;
    stall_max = smax;
    @(posedge clk);
  endtask

  // mostly well-formed frames on a rising time line, with some noise,
  // backward steps and jumps across the whole timestamp range
  task automatic push_stream(int n);
    int kind;
    longint unsigned s, e, back;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 3) begin
        push_frame('0, rand_ts());
      end else if (kind < 6) begin
        s = 64'(rand_ts());
        if (s < 2) s = 2;
        e = 64'(rand_ts()) % s;
        push_frame(wfrm_pkg::TS_W'(s), wfrm_pkg::TS_W'(e));
      end else begin
        if (kind < 9) begin
          back = $urandom_range(1, 3 * frame_len_max);
          cur_time = (cur_time > back) ? cur_time - back : 64'd1;
        end else if (kind < 11) begin
          cur_time = 64'(rand_ts()) >> $urandom_range(0, 40);
        end
        if (cur_time > 64'(wfrm_pkg::TS_MAX) - 64'd100_000_000)
          cur_time = $urandom_range(1, 1000);
        s = cur_time + $urandom_range(0, frame_gap_max);
        if (s == 0) s = 1;
        e = s + $urandom_range(0, frame_len_max);
        cur_time = e;
        push_frame(wfrm_pkg::TS_W'(s), wfrm_pkg::TS_W'(e));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, default window length
    push_frame('0, 48'd5000);
    push_frame(48'd1000, 48'd999);
    push_frame(48'd1000, 48'd17000);
    push_frame(48'd17000, 48'd33667);
    push_frame(48'd500, 48'd600);
    push_frame(48'd600, 48'd1000600);
    push_frame(wfrm_pkg::TS_MAX, wfrm_pkg::TS_MAX);
    push_frame(48'd1, wfrm_pkg::TS_MAX);
    push_frame('0, '0);
    push_frame(wfrm_pkg::TS_MAX, '0);

    // zero length acts as 1 us; many zero-length frames then saturate the rate
    start_phase('0, 2, 2);
    for (int i = 0; i < 16; i++) push_frame(48'd5000, 48'd5000);
    push_frame(48'd5000, 48'd5001);

    // shortest window, no idling on either side
    start_phase(26'd1, 0, 0);
    frame_len_max = 20;
    frame_gap_max = 5;
    push_stream(150);

    start_phase(26'd16667, 10, 10);
    frame_len_max = 20000;
    frame_gap_max = 2000;
    push_stream(400);

    // long receiver hold while frames keep coming
    start_phase(26'd100000, 10, 10);
    push_stream(400);
    @(posedge clk);
    hold_left = 300;

    start_phase('1, 5, 5);
    frame_len_max = 2_000_000;
    frame_gap_max = 100000;
    push_stream(200);

    start_phase(wfrm_pkg::WLEN_W'($urandom_range(1, 300000)), 10, 3);
    frame_len_max = 30000;
    frame_gap_max = 1000;
    push_stream(400);

    start_phase(wfrm_pkg::WLEN_RESET, 3, 10);
    frame_len_max = 100000;
    frame_gap_max = 20000;
    push_stream(400);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && error_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/wfrm_pkg.sv
rtl/wfrm_div.sv
rtl/windowed_frame_rate_monitor.sv
rtl/wfrm_chk.sv
tb/tb.sv
